// ===== sv/pdl_pkg.sv =====
// shared types and constants for the password door lock controller
// no dependencies; imported by every module of the block
`default_nettype none

package pdl_pkg;

	localparam int unsigned BYTE_W = 8;

	// command bytes
	localparam logic [BYTE_W-1:0] CMD_SET    = 8'h2B;
	localparam logic [BYTE_W-1:0] CMD_ALARM  = 8'h40;
	localparam logic [BYTE_W-1:0] CMD_DOOR   = 8'h25;
	localparam logic [BYTE_W-1:0] CMD_VERIFY = 8'h23;

	localparam logic [BYTE_W-1:0] TICK_MAX = 8'hFF;

	// configuration register indexes
	localparam logic [1:0] REG_BUZZER_END = 2'd0;
	localparam logic [1:0] REG_OPEN_END   = 2'd1;
	localparam logic [1:0] REG_HOLD_END   = 2'd2;
	localparam logic [1:0] REG_CLOSE_END  = 2'd3;

	localparam logic [BYTE_W-1:0] RST_BUZZER_END = 8'd61;
	localparam logic [BYTE_W-1:0] RST_OPEN_END   = 8'd16;
	localparam logic [BYTE_W-1:0] RST_HOLD_END   = 8'd19;
	localparam logic [BYTE_W-1:0] RST_CLOSE_END  = 8'd34;

	// motor drive codes
	localparam logic [1:0] MOTOR_STOP = 2'd0;
	localparam logic [1:0] MOTOR_CW   = 2'd1;
	localparam logic [1:0] MOTOR_CCW  = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SET1,
		PH_SET2,
		PH_VERIFY,
		PH_BUZZ,
		PH_OPEN,
		PH_HOLD,
		PH_CLOSE
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] buzzer_end;
		logic [BYTE_W-1:0] open_end;
		logic [BYTE_W-1:0] hold_end;
		logic [BYTE_W-1:0] close_end;
	} cfg_t;

	typedef struct packed {
		logic              wr_first;
		logic              wr_stored;
		logic [BYTE_W-1:0] data;
	} store_wr_t;

	typedef struct packed {
		logic       reply_valid;
		logic       reply_match;
		logic       alarm_on;
		logic [1:0] motor_drive;
		logic       busy_res;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/pdl_cmd_if.sv =====
// input channel: received bytes and timer ticks with valid/ready handshake
// standalone interface, no dependencies
`default_nettype none

interface pdl_cmd_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink (input valid, input action, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/pdl_rsp_if.sv =====
// result channel: reply, buzzer, motor and busy status with valid/ready handshake
// standalone interface, no dependencies
`default_nettype none

interface pdl_rsp_if;
	logic       valid;
	logic       ready;
	logic       reply_valid;
	logic       reply_match;
	logic       alarm_on;
	logic [1:0] motor_drive;
	logic       busy_res;

	modport source (output valid, output reply_valid, output reply_match,
		output alarm_on, output motor_drive, output busy_res, input ready);
	modport sink (input valid, input reply_valid, input reply_match,
		input alarm_on, input motor_drive, input busy_res, output ready);
endinterface

`default_nettype wire

// ===== sv/pdl_entry_store.sv =====
// storage for the first password entry and the stored password
// depends on pdl_pkg; no reset, entries are undefined until written
`default_nettype none

module pdl_entry_store #(
	parameter int unsigned PASS_LEN = 5,
	parameter int unsigned IDX_W    = 3
) (
	input  wire logic                      clk,
	input  wire logic [IDX_W-1:0]          idx,
	input  wire pdl_pkg::store_wr_t        wr,
	output logic [pdl_pkg::BYTE_W-1:0]     first_rd,
	output logic [pdl_pkg::BYTE_W-1:0]     stored_rd
);
	import pdl_pkg::*;

	logic [BYTE_W-1:0] first_q  [PASS_LEN];
	logic [BYTE_W-1:0] stored_q [PASS_LEN];

	always_ff @(posedge clk) begin
		if (wr.wr_first) begin
			first_q[idx] <= wr.data;
		end
		if (wr.wr_stored) begin
			stored_q[idx] <= wr.data;
		end
	end

	assign first_rd  = first_q[idx];
	assign stored_rd = stored_q[idx];

endmodule

`default_nettype wire

// ===== sv/pdl_ctrl.sv =====
// phase state machine, entry counter, match flag and tick counter
// depends on pdl_pkg; drives pdl_entry_store and produces one result per item
`default_nettype none

module pdl_ctrl #(
	parameter int unsigned PASS_LEN = 5,
	parameter int unsigned IDX_W    = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic                  action,
	input  wire logic [7:0]            rx_byte,
	input  wire pdl_pkg::cfg_t         cfg,
	input  wire logic [7:0]            first_rd,
	input  wire logic [7:0]            stored_rd,
	output logic [IDX_W-1:0]           idx,
	output pdl_pkg::store_wr_t         wr,
	output pdl_pkg::result_t           result
);
	import pdl_pkg::*;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PASS_LEN - 1);

	phase_t            phase_q, phase_d, phase_pre;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic              ok_q, ok_d, ok_new;
	logic [BYTE_W-1:0] tick_q, tick_d;
	logic              last, hit, rvalid, rmatch;

	assign idx  = idx_q;
	assign last = (idx_q == IDX_LAST);
	assign hit  = ((phase_q == PH_SET2) ? first_rd : stored_rd) == rx_byte;
	assign ok_new = ok_q & hit;

	// next state
	always_comb begin
		phase_pre = phase_q;
		idx_d     = idx_q;
		ok_d      = ok_q;
		tick_d    = tick_q;
		rvalid    = 1'b0;
		rmatch    = 1'b0;
		wr        = '0;
		wr.data   = rx_byte;
		if (action) begin
			if (phase_q inside {PH_BUZZ, PH_OPEN, PH_HOLD, PH_CLOSE}) begin
				tick_d = (tick_q == TICK_MAX) ? tick_q : 8'(tick_q + 8'd1);
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					case (rx_byte)
						CMD_SET: begin
							phase_pre = PH_SET1;
							idx_d     = '0;
							ok_d      = 1'b1;
						end
						CMD_VERIFY: begin
							phase_pre = PH_VERIFY;
							idx_d     = '0;
							ok_d      = 1'b1;
						end
						CMD_ALARM: begin
							phase_pre = PH_BUZZ;
							tick_d    = '0;
						end
						CMD_DOOR: begin
							phase_pre = PH_OPEN;
							tick_d    = '0;
						end
						default: ;
					endcase
				end
				PH_SET1: begin
					wr.wr_first = 1'b1;
					if (last) begin
						phase_pre = PH_SET2;
						idx_d     = '0;
						ok_d      = 1'b1;
					end else begin
						idx_d = IDX_W'(idx_q + 1'b1);
					end
				end
				PH_SET2, PH_VERIFY: begin
					wr.wr_stored = (phase_q == PH_SET2);
					if (last) begin
						rvalid    = 1'b1;
						rmatch    = ok_new;
						phase_pre = PH_IDLE;
						idx_d     = '0;
						ok_d      = 1'b1;
					end else begin
						ok_d  = ok_new;
						idx_d = IDX_W'(idx_q + 1'b1);
					end
				end
				default: ;
			endcase
		end

		// timed stages end as soon as the tick count has reached their limit
		phase_d = phase_pre;
		if (phase_d == PH_BUZZ && tick_d >= cfg.buzzer_end) phase_d = PH_IDLE;
		if (phase_d == PH_OPEN && tick_d >= cfg.open_end) phase_d = PH_HOLD;
		if (phase_d == PH_HOLD && tick_d >= cfg.hold_end) phase_d = PH_CLOSE;
		if (phase_d == PH_CLOSE && tick_d >= cfg.close_end) phase_d = PH_IDLE;

		if (!step) begin
			wr = '0;
			wr.data = rx_byte;
		end
	end

	// outputs
	always_comb begin
		result.reply_valid = rvalid;
		result.reply_match = rmatch;
		result.alarm_on    = (phase_d == PH_BUZZ);
		case (phase_d)
			PH_OPEN:  result.motor_drive = MOTOR_CW;
			PH_CLOSE: result.motor_drive = MOTOR_CCW;
			default:  result.motor_drive = MOTOR_STOP;
		endcase
		result.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			ok_q    <= 1'b1;
			tick_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			ok_q    <= ok_d;
			tick_q  <= tick_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/password_door_lock_controller.sv =====
// Password door lock controller. Each transaction on cmd carries either a received
// byte (action 0) or a timer tick (action 1) and produces exactly one transaction on
// rsp with the reply, buzzer, motor and busy status after that item. The block takes
// one item per clock cycle while rsp is not stalled; an item passes an input register
// and then the result register, which drives rsp, and a stalled rsp holds the pipeline
// back through the ready chain. Registers buzzer_end, open_end, hold_end and close_end
// (indexes 0 to 3 on cfg_idx) are to be written with cfg_we only while the block is
// idle; the block does not enforce this. The two password stores have no reset:
// verifying before any password set compares against undefined contents.
`default_nettype none

module password_door_lock_controller #(
	parameter int unsigned PASS_LEN = 5
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	pdl_cmd_if.sink         cmd,
	pdl_rsp_if.source       rsp,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [7:0] cfg_data
);
	import pdl_pkg::*;

	localparam int unsigned IDX_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;

	cfg_t              cfg_q;
	logic              valid_s1, action_s1;
	logic [BYTE_W-1:0] rx_byte_s1;
	logic              res_valid_q;
	result_t           res_q, result;
	logic              adv, step;
	logic [IDX_W-1:0]  idx;
	store_wr_t         wr;
	logic [BYTE_W-1:0] first_rd, stored_rd;

	assign adv       = !res_valid_q || rsp.ready;
	assign step      = valid_s1 && adv;
	assign cmd.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buzzer_end <= RST_BUZZER_END;
			cfg_q.open_end   <= RST_OPEN_END;
			cfg_q.hold_end   <= RST_HOLD_END;
			cfg_q.close_end  <= RST_CLOSE_END;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BUZZER_END: cfg_q.buzzer_end <= cfg_data;
				REG_OPEN_END:   cfg_q.open_end   <= cfg_data;
				REG_HOLD_END:   cfg_q.hold_end   <= cfg_data;
				REG_CLOSE_END:  cfg_q.close_end  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			action_s1  <= cmd.action;
			rx_byte_s1 <= cmd.rx_byte;
		end
	end

	pdl_entry_store #(
		.PASS_LEN (PASS_LEN),
		.IDX_W    (IDX_W)
	) u_store (
		.clk       (clk),
		.idx       (idx),
		.wr        (wr),
		.first_rd  (first_rd),
		.stored_rd (stored_rd)
	);

	pdl_ctrl #(
		.PASS_LEN (PASS_LEN),
		.IDX_W    (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.action    (action_s1),
		.rx_byte   (rx_byte_s1),
		.cfg       (cfg_q),
		.first_rd  (first_rd),
		.stored_rd (stored_rd),
		.idx       (idx),
		.wr        (wr),
		.result    (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= result;
		end
	end

	assign rsp.valid       = res_valid_q;
	assign rsp.reply_valid = res_q.reply_valid;
	assign rsp.reply_match = res_q.reply_match;
	assign rsp.alarm_on    = res_q.alarm_on;
	assign rsp.motor_drive = res_q.motor_drive;
	assign rsp.busy_res    = res_q.busy_res;

`ifndef SYNTHESIS
	// a reply always closes the command
	a_reply_ends_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.reply_valid |-> !res_q.busy_res)
		else $error("reply sent while command still busy");

	a_match_needs_reply: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.reply_match |-> res_q.reply_valid)
		else $error("match flag without reply");

	a_buzz_motor_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.alarm_on |-> res_q.motor_drive == MOTOR_STOP)
		else $error("buzzer and motor active together");

	// an item in the input register moves on whenever the result side can take it
	a_no_stall_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !res_valid_q |=> res_valid_q)
		else $error("pipeline stalled with free result register");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_password_door_lock_controller.sv =====
// self-checking testbench for password_door_lock_controller: directed table then random traffic
// keeps its own model of the lock and checks every rsp transaction against it or the directed table
// depends on pdl_pkg, pdl_cmd_if, pdl_rsp_if and the rtl top level
`timescale 1ns / 100ps

module tb_password_door_lock_controller;
	import pdl_pkg::*;

	localparam int unsigned PW_LEN      = 5;
	localparam int unsigned QUIET_LIMIT = 2000;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam result_t ST_IDLE = '0;
	localparam result_t ST_BUSY = '{reply_valid: 1'b0, reply_match: 1'b0, alarm_on: 1'b0,
		motor_drive: MOTOR_STOP, busy_res: 1'b1};
	localparam result_t ST_BUZZ = '{reply_valid: 1'b0, reply_match: 1'b0, alarm_on: 1'b1,
		motor_drive: MOTOR_STOP, busy_res: 1'b1};

	typedef struct packed {
		logic       act;
		logic [7:0] b;
		logic       typed;
		result_t    want;
	} dir_row_t;

	// rows with typed set carry their status; the rest come from the lock model
	localparam dir_row_t DIR_TAB [25] = '{
		'{ACT_TICK, 8'h5A,      1'b1, ST_IDLE},
		'{ACT_BYTE, 8'h00,      1'b1, ST_IDLE},
		'{ACT_BYTE, 8'hFF,      1'b1, ST_IDLE},
		'{ACT_BYTE, CMD_SET,    1'b1, ST_BUSY},
		'{ACT_TICK, 8'hA5,      1'b1, ST_BUSY},
		'{ACT_BYTE, 8'h00,      1'b0, ST_IDLE},
		'{ACT_BYTE, 8'hFF,      1'b0, ST_IDLE},
		'{ACT_BYTE, 8'h80,      1'b0, ST_IDLE},
		'{ACT_BYTE, 8'h01,      1'b0, ST_IDLE},
		'{ACT_BYTE, 8'h7F,      1'b0, ST_IDLE},
		'{ACT_BYTE, 8'h00,      1'b0, ST_IDLE},
		'{ACT_BYTE, 8'hFF,      1'b0, ST_IDLE},
		'{ACT_BYTE, 8'h80,      1'b0, ST_IDLE},
		'{ACT_BYTE, 8'h01,      1'b0, ST_IDLE},
		'{ACT_BYTE, 8'h7F,      1'b0, ST_IDLE},
		'{ACT_BYTE, CMD_VERIFY, 1'b1, ST_BUSY},
		'{ACT_BYTE, 8'h00,      1'b0, ST_IDLE},
		'{ACT_BYTE, 8'hFF,      1'b0, ST_IDLE},
		'{ACT_BYTE, 8'h80,      1'b0, ST_IDLE},
		'{ACT_BYTE, 8'h01,      1'b0, ST_IDLE},
		'{ACT_BYTE, 8'h7E,      1'b0, ST_IDLE},
		'{ACT_BYTE, CMD_ALARM,  1'b1, ST_BUZZ},
		'{ACT_BYTE, CMD_DOOR,   1'b0, ST_IDLE},
		'{ACT_TICK, 8'h00,      1'b0, ST_IDLE},
		'{ACT_BYTE, CMD_VERIFY, 1'b0, ST_IDLE}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [7:0] cfg_data;

	pdl_cmd_if cmd_ch ();
	pdl_rsp_if rsp_ch ();

	password_door_lock_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// lock model state
	phase_t      lock_phase;
	int unsigned entry_idx;
	int unsigned hit_cnt;
	logic [7:0]  tick_cnt;
	logic [7:0]  first_m [PW_LEN];
	logic [7:0]  stored_m [PW_LEN];
	cfg_t        regs;
	bit          pass_known;
	bit          aim_match;

	result_t     status_q [$];
	int unsigned fail_count   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned burst_left   = 0;

	// stages may fall through in one step when the ends are low or out of order
	function automatic void close_timed();
		if (lock_phase == PH_BUZZ && tick_cnt >= regs.buzzer_end)
			lock_phase = PH_IDLE;
		if (lock_phase == PH_OPEN && tick_cnt >= regs.open_end)
			lock_phase = PH_HOLD;
		if (lock_phase == PH_HOLD && tick_cnt >= regs.hold_end)
			lock_phase = PH_CLOSE;
		if (lock_phase == PH_CLOSE && tick_cnt >= regs.close_end)
			lock_phase = PH_IDLE;
	endfunction

	function automatic result_t lock_step(input logic act, input logic [7:0] b);
		result_t r;
		r = '0;
		if (act == ACT_TICK) begin
			// buzz, open, hold and close sit at the top of the phase encoding
			if (lock_phase >= PH_BUZZ) begin
				if (tick_cnt != TICK_MAX)
					tick_cnt = tick_cnt + 8'd1;
				close_timed();
			end
		end else begin
			case (lock_phase)
				PH_IDLE: begin
					case (b)
						CMD_SET: begin
							lock_phase = PH_SET1;
							entry_idx = 0;
							hit_cnt = 0;
						end
						CMD_VERIFY: begin
							lock_phase = PH_VERIFY;
							entry_idx = 0;
							hit_cnt = 0;
						end
						CMD_ALARM: begin
							lock_phase = PH_BUZZ;
							tick_cnt = '0;
							close_timed();
						end
						CMD_DOOR: begin
							lock_phase = PH_OPEN;
							tick_cnt = '0;
							close_timed();
						end
						default: ;
					endcase
				end
				PH_SET1: begin
					first_m[entry_idx] = b;
					entry_idx++;
					if (entry_idx == PW_LEN) begin
						entry_idx = 0;
						hit_cnt = 0;
						lock_phase = PH_SET2;
					end
				end
				PH_SET2, PH_VERIFY: begin
					if (lock_phase == PH_SET2) begin
						if (first_m[entry_idx] == b)
							hit_cnt++;
						stored_m[entry_idx] = b;
					end else if (stored_m[entry_idx] == b) begin
						hit_cnt++;
					end
					entry_idx++;
					if (entry_idx == PW_LEN) begin
						r.reply_valid = 1'b1;
						r.reply_match = (hit_cnt == PW_LEN);
						if (lock_phase == PH_SET2)
							pass_known = 1'b1;
						entry_idx = 0;
						hit_cnt = 0;
						lock_phase = PH_IDLE;
					end
				end
				default: ; // bytes dropped during timed actions
			endcase
		end
		r.alarm_on = (lock_phase == PH_BUZZ);
		r.motor_drive = (lock_phase == PH_OPEN) ? MOTOR_CW :
			(lock_phase == PH_CLOSE) ? MOTOR_CCW : MOTOR_STOP;
		r.busy_res = (lock_phase != PH_IDLE);
		return r;
	endfunction

	function automatic logic [7:0] pick_end();
		return 8'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) :
			$urandom_range(1, 40));
	endfunction

	// one cmd transaction, with burst/gap pacing in front of it
	task automatic push_item(input logic act, input logic [7:0] b, input bit typed,
		input result_t want);
		int unsigned gap;
		result_t     exp;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) :
				$urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.rx_byte <= b;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		burst_left--;
		exp = lock_step(act, b);
		if (typed)
			exp = want;
		status_q.push_back(exp);
	endtask

	task automatic hold_off();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (status_q.size() != 0);
	endtask

	// mostly well-formed command sequences, with ticks and stray bytes mixed in
	task automatic random_items(input int unsigned n);
		int unsigned r;
		logic        act;
		logic [7:0]  b;
		for (int unsigned i = 0; i < n; i++) begin
			act = ACT_BYTE;
			b = 8'($urandom_range(0, 255));
			case (lock_phase)
				PH_IDLE: begin
					if ($urandom_range(0, 59) == 0)
						hold_off();
					r = $urandom_range(0, 99);
					aim_match = ($urandom_range(0, 9) < 6);
					if (r < 25)
						b = CMD_SET;
					else if (r < 50)
						b = pass_known ? CMD_VERIFY : CMD_SET;
					else if (r < 63)
						b = CMD_ALARM;
					else if (r < 76)
						b = CMD_DOOR;
					else if (r >= 90)
						act = ACT_TICK;
					// no verify until a password has been stored
					if (b == CMD_VERIFY && !pass_known)
						b = b ^ 8'h01;
				end
				PH_SET1: begin
					if ($urandom_range(0, 9) == 0)
						act = ACT_TICK;
				end
				PH_SET2, PH_VERIFY: begin
					if ($urandom_range(0, 9) == 0)
						act = ACT_TICK;
					else if (aim_match || $urandom_range(0, 2) != 0)
						b = (lock_phase == PH_SET2) ? first_m[entry_idx] : stored_m[entry_idx];
				end
				default: begin
					if ($urandom_range(0, 11) != 0)
						act = ACT_TICK;
				end
			endcase
			push_item(act, b, 1'b0, ST_IDLE);
		end
	endtask

	// finish whatever is running so the registers change only while idle
	task automatic settle_idle();
		while (lock_phase != PH_IDLE)
			push_item((lock_phase >= PH_BUZZ) ? ACT_TICK : ACT_BYTE,
				8'($urandom_range(0, 255)), 1'b0, ST_IDLE);
		hold_off();
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input cfg_t c);
		cfg_we <= 1'b1;
		cfg_idx <= REG_BUZZER_END;
		cfg_data <= c.buzzer_end;
		@(posedge clk);
		cfg_idx <= REG_OPEN_END;
		cfg_data <= c.open_end;
		@(posedge clk);
		cfg_idx <= REG_HOLD_END;
		cfg_data <= c.hold_end;
		@(posedge clk);
		cfg_idx <= REG_CLOSE_END;
		cfg_data <= c.close_end;
		@(posedge clk);
		cfg_we <= 1'b0;
		regs = c;
	endtask

	initial begin : rsp_side
		int unsigned cyc;
		result_t     got;
		result_t     want;
		cyc = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.reply_valid = rsp_ch.reply_valid;
				got.reply_match = rsp_ch.reply_match;
				got.alarm_on = rsp_ch.alarm_on;
				got.motor_drive = rsp_ch.motor_drive;
				got.busy_res = rsp_ch.busy_res;
				if (status_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected rsp transaction rv=%b rm=%b bz=%b mot=%0d busy=%b",
						$time, got.reply_valid, got.reply_match, got.alarm_on,
						got.motor_drive, got.busy_res);
				end else begin
					want = status_q.pop_front();
					if (got !== want) begin
						fail_count++;
						$display("%0t: status mismatch expected rv=%b rm=%b bz=%b mot=%0d busy=%b",
							$time, want.reply_valid, want.reply_match, want.alarm_on,
							want.motor_drive, want.busy_res);
						$display("%0t:                   actual rv=%b rm=%b bz=%b mot=%0d busy=%b",
							$time, got.reply_valid, got.reply_match, got.alarm_on,
							got.motor_drive, got.busy_res);
					end
				end
			end
			if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			// receiver ready pattern steps through four modes: always ready, random, periodic, mostly stalled
			case ((cyc / 256) % 4)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				2: rsp_ch.ready <= ((cyc % 7) < 4);
				default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
			cyc++;
		end
	end

	initial begin : watchdog
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("[password_door_lock_controller] ERROR");
		$finish;
	end

	initial begin : stim
		cfg_t c;
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.action <= ACT_BYTE;
		cmd_ch.rx_byte <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_BUZZER_END;
		cfg_data <= '0;
		lock_phase = PH_IDLE;
		entry_idx = 0;
		hit_cnt = 0;
		tick_cnt = '0;
		pass_known = 1'b0;
		aim_match = 1'b0;
		regs = '{buzzer_end: RST_BUZZER_END, open_end: RST_OPEN_END,
			hold_end: RST_HOLD_END, close_end: RST_CLOSE_END};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TAB[i])
			push_item(DIR_TAB[i].act, DIR_TAB[i].b, DIR_TAB[i].typed, DIR_TAB[i].want);
		random_items(275);

		for (int p = 1; p < 7; p++) begin
			settle_idle();
			case (p)
				1: c = '{buzzer_end: 8'd1, open_end: 8'd1, hold_end: 8'd1, close_end: 8'd1};
				2: c = '{buzzer_end: 8'd255, open_end: 8'd255, hold_end: 8'd255,
					close_end: 8'd255};
				// ends out of order: hold and close fall through on the tick that ends the open stage
				3: c = '{buzzer_end: 8'd40, open_end: 8'd30, hold_end: 8'd12, close_end: 8'd5};
				default: begin
					c.buzzer_end = pick_end();
					c.open_end = pick_end();
					c.hold_end = pick_end();
					c.close_end = pick_end();
				end
			endcase
			write_regs(c);
			random_items(260);
		end

		hold_off();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && status_q.size() == 0)
			$display("[password_door_lock_controller] OK");
		else
			$display("[password_door_lock_controller] ERROR");
		$finish;
	end

endmodule
